/* sv/abps_pkg.sv */
// shared types, constants and register codes for the alarm buzzer pattern sequencer
package abps_pkg;

    localparam int DEFAULT_PHASE_BITS = 12;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;
    localparam int DUTY_W     = 10;
    localparam int STATUS_W   = 8;
    localparam int ALARM_W    = 3;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAST_PERIOD   = 4'd0,
        CFG_FAST_ON_TICKS = 4'd1,
        CFG_LONG_PERIOD   = 4'd2,
        CFG_LONG_ON_TICKS = 4'd3,
        CFG_TRIPLE_PERIOD = 4'd4,
        CFG_BEEP_LENGTH   = 4'd5,
        CFG_BEEP_SPACING  = 4'd6,
        CFG_ON_DUTY       = 4'd7
    } cfg_idx_t;

    localparam logic [CFG_DATA_W-1:0] RST_FAST_PERIOD   = 12'd6;
    localparam logic [CFG_DATA_W-1:0] RST_FAST_ON_TICKS = 12'd3;
    localparam logic [CFG_DATA_W-1:0] RST_LONG_PERIOD   = 12'd40;
    localparam logic [CFG_DATA_W-1:0] RST_LONG_ON_TICKS = 12'd10;
    localparam logic [CFG_DATA_W-1:0] RST_TRIPLE_PERIOD = 12'd250;
    localparam logic [CFG_DATA_W-1:0] RST_BEEP_LENGTH   = 12'd6;
    localparam logic [CFG_DATA_W-1:0] RST_BEEP_SPACING  = 12'd12;
    localparam logic [DUTY_W-1:0]     RST_ON_DUTY       = 10'd512;

    // item modes
    localparam logic MODE_TICK     = 1'b0;
    localparam logic MODE_SET_MUTE = 1'b1;

    // result codes
    localparam logic RESULT_OK        = 1'b0;
    localparam logic RESULT_SAVE_FAIL = 1'b1;

    // status byte bits
    localparam int STATUS_INTERLOCK_BIT = 5;
    localparam int STATUS_OT_SOFT_BIT   = 0;

    // alarm mask bits
    localparam int ALARM_INTERLOCK_BIT = 0;
    localparam int ALARM_DEGRADED_BIT  = 1;
    localparam int ALARM_OT_SOFT_BIT   = 2;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] fast_period;
        logic [CFG_DATA_W-1:0] fast_on_ticks;
        logic [CFG_DATA_W-1:0] long_period;
        logic [CFG_DATA_W-1:0] long_on_ticks;
        logic [CFG_DATA_W-1:0] triple_period;
        logic [CFG_DATA_W-1:0] beep_length;
        logic [CFG_DATA_W-1:0] beep_spacing;
    } tone_cfg_t;

    typedef struct packed {
        logic fast_on;
        logic long_on;
        logic triple_on;
    } tone_hit_t;

endpackage

/* sv/abps_item_if.sv */
// input item channel: tick or set-mute beats
interface abps_item_if import abps_pkg::*;;
    logic                valid;
    logic                ready;
    logic                mode;
    logic [STATUS_W-1:0] status_byte;
    logic                bus_degraded;
    logic                mute_request;
    logic                save_ok;

    modport source (output valid, mode, status_byte, bus_degraded, mute_request, save_ok,
                    input ready);
    modport sink   (input valid, mode, status_byte, bus_degraded, mute_request, save_ok,
                    output ready);
endinterface

/* sv/abps_result_if.sv */
// result channel: buzzer duty and annunciator status beats
interface abps_result_if import abps_pkg::*;;
    logic               valid;
    logic               ready;
    logic [DUTY_W-1:0]  buzzer_duty;
    logic               muted_now;
    logic [ALARM_W-1:0] alarm_bits;
    logic               result_code;

    modport source (output valid, buzzer_duty, muted_now, alarm_bits, result_code,
                    input ready);
    modport sink   (input valid, buzzer_duty, muted_now, alarm_bits, result_code,
                    output ready);
endinterface

/* sv/abps_cfg_if.sv */
// configuration write channel
interface abps_cfg_if import abps_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/abps_tone_gen.sv */
// per-pattern phase counters and beep window decode
module abps_tone_gen import abps_pkg::*;
#(
    parameter int PHASE_BITS = DEFAULT_PHASE_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  tone_cfg_t tone_cfg,
    input  logic      advance,
    output tone_hit_t hit
);

    localparam int CMP_W = ((PHASE_BITS > CFG_DATA_W) ? PHASE_BITS : CFG_DATA_W) + 2;

    logic [PHASE_BITS-1:0] fast_phase_reg,   fast_phase_next;
    logic [PHASE_BITS-1:0] long_phase_reg,   long_phase_next;
    logic [PHASE_BITS-1:0] triple_phase_reg, triple_phase_next;

    logic [CMP_W-1:0] t_x, len_x, sp_x, sp2_x, end1_x, end2_x;

    // wraps at the period (zero counts as one) and at the counter limit
    function automatic logic [PHASE_BITS-1:0] phase_step(
        input logic [PHASE_BITS-1:0] ph,
        input logic [CFG_DATA_W-1:0] per
    );
        logic [PHASE_BITS:0] n;
        logic [CMP_W-1:0]    n_x;
        logic [CMP_W-1:0]    per_x;
        n     = {1'b0, ph} + (PHASE_BITS+1)'(1);
        n_x   = CMP_W'(n);
        per_x = (per == '0) ? CMP_W'(1) : CMP_W'(per);
        if (n[PHASE_BITS] || (n_x >= per_x))
        begin
            return '0;
        end
        return n[PHASE_BITS-1:0];
    endfunction

    always_comb
    begin
        fast_phase_next   = fast_phase_reg;
        long_phase_next   = long_phase_reg;
        triple_phase_next = triple_phase_reg;
        if (advance)
        begin
            fast_phase_next   = phase_step(fast_phase_reg, tone_cfg.fast_period);
            long_phase_next   = phase_step(long_phase_reg, tone_cfg.long_period);
            triple_phase_next = phase_step(triple_phase_reg, tone_cfg.triple_period);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_phase_reg   <= '0;
            long_phase_reg   <= '0;
            triple_phase_reg <= '0;
        end
        else
        begin
            fast_phase_reg   <= fast_phase_next;
            long_phase_reg   <= long_phase_next;
            triple_phase_reg <= triple_phase_next;
        end
    end

    // three short beep windows
    always_comb
    begin
        t_x    = CMP_W'(triple_phase_reg);
        len_x  = CMP_W'(tone_cfg.beep_length);
        sp_x   = CMP_W'(tone_cfg.beep_spacing);
        sp2_x  = sp_x << 1;
        end1_x = sp_x + len_x;
        end2_x = sp2_x + len_x;
    end

    assign hit.fast_on   = CMP_W'(fast_phase_reg) < CMP_W'(tone_cfg.fast_on_ticks);
    assign hit.long_on   = CMP_W'(long_phase_reg) < CMP_W'(tone_cfg.long_on_ticks);
    assign hit.triple_on = (t_x < len_x)
                        || ((t_x >= sp_x)  && (t_x < end1_x))
                        || ((t_x >= sp2_x) && (t_x < end2_x));

endmodule

/* sv/alarm_buzzer_pattern_sequencer_top.sv */
// top level of the alarm buzzer pattern sequencer
//
// channels: item (sink) takes tick beats (mode 0, status byte and bus-degraded
// flag) and set-mute beats (mode 1, requested mute and save outcome); result
// (source) gives exactly one beat per item with buzzer duty, mute state, alarm
// mask and result code; cfg (sink) writes one register per beat, always ready,
// indexes beyond the register map are dropped
// latency: the result of an item is valid the cycle after its beat is taken
// throughput: one item per cycle while results are taken; the whole step is a
// handful of compares in the phase counter unit and the mute logic, all between
// the item port and the result register
// stall: item ready stays high while the result register is empty or being
// drained in the same cycle; a held result blocks new items, nothing is dropped
// reset: mute off, previous alarm mask zero, all phase counters zero, buzzer
// silent, registers back to their defaults, result register empty
module alarm_buzzer_pattern_sequencer_top import abps_pkg::*;
#(
    parameter int PHASE_BITS = DEFAULT_PHASE_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    abps_item_if.sink          item,
    abps_result_if.source      result,
    abps_cfg_if.sink           cfg
);

    // configuration registers
    tone_cfg_t         tone_cfg_reg;
    logic [DUTY_W-1:0] on_duty_reg;

    // annunciator state
    logic               mute_reg,      mute_next;
    logic [ALARM_W-1:0] prev_mask_reg, prev_mask_next;
    logic               sounding_reg,  sounding_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [DUTY_W-1:0]  duty_reg,      duty_next;
    logic               muted_out_reg, muted_out_next;
    logic [ALARM_W-1:0] alarm_reg,     alarm_next;
    logic               code_reg,      code_next;

    logic               accept;
    logic               tick_accept;
    logic [ALARM_W-1:0] mask;
    logic [ALARM_W-1:0] rising;
    logic               failed;
    tone_hit_t          hit;

    // accept while the result register is empty or drains this cycle
    assign item.ready  = !out_valid_reg || result.ready;
    assign accept      = item.valid && item.ready;
    assign tick_accept = accept && (item.mode == MODE_TICK);
    assign cfg.ready   = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_cfg_reg.fast_period   <= RST_FAST_PERIOD;
            tone_cfg_reg.fast_on_ticks <= RST_FAST_ON_TICKS;
            tone_cfg_reg.long_period   <= RST_LONG_PERIOD;
            tone_cfg_reg.long_on_ticks <= RST_LONG_ON_TICKS;
            tone_cfg_reg.triple_period <= RST_TRIPLE_PERIOD;
            tone_cfg_reg.beep_length   <= RST_BEEP_LENGTH;
            tone_cfg_reg.beep_spacing  <= RST_BEEP_SPACING;
            on_duty_reg                <= RST_ON_DUTY;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_FAST_PERIOD:   tone_cfg_reg.fast_period   <= cfg.data;
                CFG_FAST_ON_TICKS: tone_cfg_reg.fast_on_ticks <= cfg.data;
                CFG_LONG_PERIOD:   tone_cfg_reg.long_period   <= cfg.data;
                CFG_LONG_ON_TICKS: tone_cfg_reg.long_on_ticks <= cfg.data;
                CFG_TRIPLE_PERIOD: tone_cfg_reg.triple_period <= cfg.data;
                CFG_BEEP_LENGTH:   tone_cfg_reg.beep_length   <= cfg.data;
                CFG_BEEP_SPACING:  tone_cfg_reg.beep_spacing  <= cfg.data;
                CFG_ON_DUTY:       on_duty_reg                <= cfg.data[DUTY_W-1:0];
                default:           ;
            endcase
        end
    end

    // phase counters advance on tick beats only; hit flags use the old phase
    abps_tone_gen #(
        .PHASE_BITS (PHASE_BITS)
    ) u_tone_gen (
        .clk      (clk),
        .rst_n    (rst_n),
        .tone_cfg (tone_cfg_reg),
        .advance  (tick_accept),
        .hit      (hit)
    );

    // alarm mask and newly raised bits
    always_comb
    begin
        mask = '0;
        mask[ALARM_INTERLOCK_BIT] = item.status_byte[STATUS_INTERLOCK_BIT];
        mask[ALARM_DEGRADED_BIT]  = item.bus_degraded;
        mask[ALARM_OT_SOFT_BIT]   = item.status_byte[STATUS_OT_SOFT_BIT];
        rising = mask & ~prev_mask_reg;
    end

    // mute handling and pattern select
    always_comb
    begin
        mute_next      = mute_reg;
        prev_mask_next = prev_mask_reg;
        sounding_next  = sounding_reg;
        failed         = 1'b0;
        code_next      = code_reg;
        alarm_next     = alarm_reg;

        if (accept)
        begin
            if (item.mode == MODE_SET_MUTE)
            begin
                code_next  = RESULT_OK;
                alarm_next = '0;
                if (mute_reg == item.mute_request)
                begin
                    if (item.mute_request)
                    begin
                        sounding_next = 1'b0;
                    end
                end
                else if (!item.save_ok)
                begin
                    code_next = RESULT_SAVE_FAIL;
                end
                else
                begin
                    mute_next = item.mute_request;
                    if (item.mute_request)
                    begin
                        sounding_next = 1'b0;
                    end
                end
            end
            else
            begin
                // auto unmute on a newly raised alarm, held only if the save works
                if (mute_reg && (rising != '0))
                begin
                    if (item.save_ok)
                    begin
                        mute_next = 1'b0;
                    end
                    else
                    begin
                        failed = 1'b1;
                    end
                end

                // priority: interlock, then degraded, then soft overtemperature
                if (mute_next)
                begin
                    sounding_next = 1'b0;
                end
                else if (mask[ALARM_INTERLOCK_BIT])
                begin
                    sounding_next = hit.fast_on;
                end
                else if (mask[ALARM_DEGRADED_BIT])
                begin
                    sounding_next = hit.long_on;
                end
                else if (mask[ALARM_OT_SOFT_BIT])
                begin
                    sounding_next = hit.triple_on;
                end
                else
                begin
                    sounding_next = 1'b0;
                end

                prev_mask_next = failed ? '0 : mask;
                alarm_next     = mask;
                code_next      = failed ? RESULT_SAVE_FAIL : RESULT_OK;
            end
        end
    end

    // result register loads on accept, empties when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        duty_next      = duty_reg;
        muted_out_next = muted_out_reg;
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            duty_next      = sounding_next ? on_duty_reg : '0;
            muted_out_next = mute_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mute_reg      <= 1'b0;
            prev_mask_reg <= '0;
            sounding_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mute_reg      <= mute_next;
            prev_mask_reg <= prev_mask_next;
            sounding_reg  <= sounding_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        duty_reg      <= duty_next;
        muted_out_reg <= muted_out_next;
        alarm_reg     <= alarm_next;
        code_reg      <= code_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.buzzer_duty = duty_reg;
    assign result.muted_now   = muted_out_reg;
    assign result.alarm_bits  = alarm_reg;
    assign result.result_code = code_reg;

    // a muted buzzer never sounds
    a_mute_silent: assert property (@(posedge clk) disable iff (!rst_n)
        mute_reg |-> !sounding_reg)
        else $error("buzzer sounding while muted");

    // item ready only drops while a result is held
    a_ready_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> out_valid_reg)
        else $error("item stalled with empty result register");

    // failed auto unmute clears the previous mask and stays muted
    a_fail_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_accept && mute_reg && !item.save_ok && (rising != '0))
        |=> (prev_mask_reg == '0) && mute_reg && (code_reg == RESULT_SAVE_FAIL))
        else $error("failed unmute did not clear previous mask");

    // a failed tick result always reports a muted block with an alarm present
    a_fail_tick_muted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (code_reg == RESULT_SAVE_FAIL) && (alarm_reg != '0))
        |-> muted_out_reg)
        else $error("save failure reported while unmuted");

endmodule

/* tb/tb_alarm_buzzer_pattern_sequencer_top.sv */
// self-checking testbench for the alarm buzzer pattern sequencer
`timescale 1ns / 1ps

module tb_alarm_buzzer_pattern_sequencer_top;
    import abps_pkg::*;

    localparam int PHASE_BITS   = DEFAULT_PHASE_BITS;
    localparam int NUM_REGS     = int'(CFG_ON_DUTY) + 1;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 120;
    localparam int PRINT_LIMIT  = 40;

    // one input beat as the block sees it
    typedef struct packed {
        logic                mode;
        logic [STATUS_W-1:0] status_byte;
        logic                bus_degraded;
        logic                mute_request;
        logic                save_ok;
    } alarm_item_t;

    // one result beat
    typedef struct packed {
        logic [DUTY_W-1:0]  duty;
        logic               muted;
        logic [ALARM_W-1:0] alarms;
        logic               code;
    } annunciation_t;

    logic clk;
    logic rst_n;

    abps_item_if   item_bus ();
    abps_result_if result_bus ();
    abps_cfg_if    cfg_bus ();

    alarm_buzzer_pattern_sequencer_top #(
        .PHASE_BITS (PHASE_BITS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // annunciator model: registers and state mirror the block's
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] reg_val [NUM_REGS];
    logic                  mute_flag;
    logic [ALARM_W-1:0]    prev_mask;
    logic [PHASE_BITS-1:0] fast_ph;
    logic [PHASE_BITS-1:0] long_ph;
    logic [PHASE_BITS-1:0] triple_ph;
    logic                  sounding;

    function automatic void model_reset();
        reg_val[CFG_FAST_PERIOD]   = RST_FAST_PERIOD;
        reg_val[CFG_FAST_ON_TICKS] = RST_FAST_ON_TICKS;
        reg_val[CFG_LONG_PERIOD]   = RST_LONG_PERIOD;
        reg_val[CFG_LONG_ON_TICKS] = RST_LONG_ON_TICKS;
        reg_val[CFG_TRIPLE_PERIOD] = RST_TRIPLE_PERIOD;
        reg_val[CFG_BEEP_LENGTH]   = RST_BEEP_LENGTH;
        reg_val[CFG_BEEP_SPACING]  = RST_BEEP_SPACING;
        reg_val[CFG_ON_DUTY]       = CFG_DATA_W'(RST_ON_DUTY);
        mute_flag = 1'b0;
        prev_mask = '0;
        fast_ph   = '0;
        long_ph   = '0;
        triple_ph = '0;
        sounding  = 1'b0;
    endfunction

    // counter advance: zero period acts as one, wrap at period or at counter width
    function automatic logic [PHASE_BITS-1:0] next_phase(input logic [PHASE_BITS-1:0] ph,
                                                         input logic [CFG_DATA_W-1:0] period);
        int unsigned n;
        int unsigned p;
        n = int'(ph) + 1;
        p = (period == '0) ? 1 : int'(period);
        if (n >= p || n > (1 << PHASE_BITS) - 1)
        begin
            n = 0;
        end
        return PHASE_BITS'(n);
    endfunction

    // work out the result of one accepted beat and move the model state on
    function automatic annunciation_t annunciate(input alarm_item_t it);
        annunciation_t      r;
        logic [ALARM_W-1:0] mask;
        logic [ALARM_W-1:0] rising;
        logic               interlock;
        logic               overtemp;
        logic               failed;
        int unsigned        t;
        int unsigned        len;
        int unsigned        sp;
        r = '0;
        if (it.mode == MODE_SET_MUTE)
        begin
            r.code = RESULT_OK;
            if (mute_flag == it.mute_request)
            begin
                if (it.mute_request)
                begin
                    sounding = 1'b0;
                end
            end
            else if (!it.save_ok)
            begin
                r.code = RESULT_SAVE_FAIL;
            end
            else
            begin
                mute_flag = it.mute_request;
                if (it.mute_request)
                begin
                    sounding = 1'b0;
                end
            end
            r.alarms = '0;
        end
        else
        begin
            interlock = it.status_byte[STATUS_INTERLOCK_BIT];
            overtemp  = it.status_byte[STATUS_OT_SOFT_BIT];
            mask = '0;
            mask[ALARM_INTERLOCK_BIT] = interlock;
            mask[ALARM_DEGRADED_BIT]  = it.bus_degraded;
            mask[ALARM_OT_SOFT_BIT]   = overtemp;
            rising = mask & ~prev_mask;
            failed = 1'b0;
            // a newly risen alarm tries to lift the mute
            if (mute_flag && rising != '0)
            begin
                if (it.save_ok)
                begin
                    mute_flag = 1'b0;
                end
                else
                begin
                    failed = 1'b1;
                end
            end
            t   = triple_ph;
            len = reg_val[CFG_BEEP_LENGTH];
            sp  = reg_val[CFG_BEEP_SPACING];
            if (mute_flag)
            begin
                sounding = 1'b0;
            end
            else if (interlock)
            begin
                sounding = (fast_ph < reg_val[CFG_FAST_ON_TICKS]);
            end
            else if (it.bus_degraded)
            begin
                sounding = (long_ph < reg_val[CFG_LONG_ON_TICKS]);
            end
            else if (overtemp)
            begin
                sounding = (t < len) || (t >= sp && t < sp + len) ||
                           (t >= 2 * sp && t < 2 * sp + len);
            end
            else
            begin
                sounding = 1'b0;
            end
            prev_mask = failed ? '0 : mask;
            fast_ph   = next_phase(fast_ph, reg_val[CFG_FAST_PERIOD]);
            long_ph   = next_phase(long_ph, reg_val[CFG_LONG_PERIOD]);
            triple_ph = next_phase(triple_ph, reg_val[CFG_TRIPLE_PERIOD]);
            r.alarms  = mask;
            r.code    = failed ? RESULT_SAVE_FAIL : RESULT_OK;
        end
        r.duty  = sounding ? reg_val[CFG_ON_DUTY][DUTY_W-1:0] : '0;
        r.muted = mute_flag;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // bookkeeping shared by the processes
    // ------------------------------------------------------------------
    alarm_item_t   pending_q [$];   // beats waiting to be offered
    annunciation_t expected_q [$];  // predicted results, oldest first
    int            n_queued;
    int            n_accepted;
    int            n_results;
    int            n_errors;
    int            n_ticks;
    int            n_mute_reqs;
    int            n_loud;
    int            n_save_fail;
    int            n_reg_writes;
    int            n_settings;
    int            cycles;
    logic          idling;          // random gaps on both sides
    int            phase_no;
    logic [ALARM_W-1:0] alarm_scene;

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        if (n_errors <= PRINT_LIMIT)
        begin
            $display("mismatch on result beat %0d: %s got %0d expected %0d",
                     n_results, what, got, want);
        end
    endtask

    // ------------------------------------------------------------------
    // item driver: offers queued beats, predicts each one as it is taken
    // ------------------------------------------------------------------
    int            send_gap;
    alarm_item_t   nxt;
    alarm_item_t   taken;
    annunciation_t pred;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_bus.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            // beat taken at this edge: predict with the values still on the bus
            if (item_bus.valid && item_bus.ready)
            begin
                taken.mode         = item_bus.mode;
                taken.status_byte  = item_bus.status_byte;
                taken.bus_degraded = item_bus.bus_degraded;
                taken.mute_request = item_bus.mute_request;
                taken.save_ok      = item_bus.save_ok;
                pred = annunciate(taken);
                expected_q.push_back(pred);
                if (taken.mode == MODE_TICK)
                begin
                    n_ticks++;
                end
                else
                begin
                    n_mute_reqs++;
                end
                if (pred.duty != '0)
                begin
                    n_loud++;
                end
                if (pred.code == RESULT_SAVE_FAIL)
                begin
                    n_save_fail++;
                end
                n_accepted++;
            end
            // bus free for a new beat, or a gap in progress
            if (!item_bus.valid || item_bus.ready)
            begin
                if (idling && send_gap > 0)
                begin
                    send_gap--;
                    item_bus.valid <= 1'b0;
                end
                else if (pending_q.size() != 0)
                begin
                    nxt = pending_q.pop_front();
                    item_bus.mode         <= nxt.mode;
                    item_bus.status_byte  <= nxt.status_byte;
                    item_bus.bus_degraded <= nxt.bus_degraded;
                    item_bus.mute_request <= nxt.mute_request;
                    item_bus.save_ok      <= nxt.save_ok;
                    item_bus.valid        <= 1'b1;
                    if (idling && $urandom_range(0, 4) == 0)
                    begin
                        send_gap = $urandom_range(1, 11);
                    end
                end
                else
                begin
                    item_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // long receiver hold-off: result side blocks while beats keep coming,
    // so the result register fills and item ready must drop
    // ------------------------------------------------------------------
    int hold_left;
    int held_phase;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            held_phase <= -1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (idling && phase_no % 4 == 1 && held_phase != phase_no &&
                 pending_q.size() != 0 && pending_q.size() <= 100)
        begin
            hold_left  <= HOLD_CYCLES;
            held_phase <= phase_no;
        end
    end

    // ------------------------------------------------------------------
    // result monitor: drives ready, checks every beat against the oldest
    // prediction field by field
    // ------------------------------------------------------------------
    int            recv_gap;
    annunciation_t want;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch("beat with nothing expected", 1, 0);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (result_bus.buzzer_duty !== want.duty)
                    begin
                        report_mismatch("buzzer_duty", result_bus.buzzer_duty, want.duty);
                    end
                    if (result_bus.muted_now !== want.muted)
                    begin
                        report_mismatch("muted_now", result_bus.muted_now, want.muted);
                    end
                    if (result_bus.alarm_bits !== want.alarms)
                    begin
                        report_mismatch("alarm_bits", result_bus.alarm_bits, want.alarms);
                    end
                    if (result_bus.result_code !== want.code)
                    begin
                        report_mismatch("result_code", result_bus.result_code, want.code);
                    end
                end
                n_results++;
            end
            // ready pattern: hold-off first, then random stalls
            if (hold_left != 0)
            begin
                result_bus.ready <= 1'b0;
            end
            else if (idling && recv_gap > 0)
            begin
                recv_gap--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= 1'b1;
                if (idling && $urandom_range(0, 7) == 0)
                begin
                    recv_gap = $urandom_range(1, 11);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycles, expected_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic alarm_item_t mk_item(input logic mode, input logic [STATUS_W-1:0] st,
                                            input logic deg, input logic req, input logic ok);
        alarm_item_t it;
        it.mode         = mode;
        it.status_byte  = st;
        it.bus_degraded = deg;
        it.mute_request = req;
        it.save_ok      = ok;
        return it;
    endfunction

    task automatic queue_item(input alarm_item_t it);
        pending_q.push_back(it);
        n_queued++;
    endtask

    // alarms persist for a while so rises and mute recovery get exercised;
    // one beat in ten has a fully random status byte
    function automatic alarm_item_t random_item();
        alarm_item_t it;
        if ($urandom_range(0, 5) == 0)
        begin
            alarm_scene = ALARM_W'($urandom_range(0, 7));
        end
        it.mode         = ($urandom_range(0, 3) == 0) ? MODE_SET_MUTE : MODE_TICK;
        it.status_byte  = STATUS_W'($urandom_range(0, 255));
        it.bus_degraded = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) != 0)
        begin
            it.status_byte[STATUS_INTERLOCK_BIT] = alarm_scene[ALARM_INTERLOCK_BIT];
            it.status_byte[STATUS_OT_SOFT_BIT]   = alarm_scene[ALARM_OT_SOFT_BIT];
            it.bus_degraded                      = alarm_scene[ALARM_DEGRADED_BIT];
        end
        it.mute_request = 1'($urandom_range(0, 1));
        it.save_ok      = ($urandom_range(0, 3) != 0);
        return it;
    endfunction

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            queue_item(random_item());
        end
    endtask

    // wait until every queued beat is taken and every result is back
    task automatic drain();
        while (n_accepted != n_queued || expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    // one register write; called at a clock edge while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        cfg_bus.valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_bus.ready);
        if (idx < NUM_REGS)
        begin
            reg_val[idx] = (idx == CFG_ON_DUTY) ? (val & {DUTY_W{1'b1}}) : val;
        end
        n_reg_writes++;
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_regs(input int fp, input int fo, input int lp, input int lo,
                             input int tp, input int bl, input int bs, input int duty);
        write_reg(CFG_FAST_PERIOD, CFG_DATA_W'(fp));
        write_reg(CFG_FAST_ON_TICKS, CFG_DATA_W'(fo));
        write_reg(CFG_LONG_PERIOD, CFG_DATA_W'(lp));
        write_reg(CFG_LONG_ON_TICKS, CFG_DATA_W'(lo));
        write_reg(CFG_TRIPLE_PERIOD, CFG_DATA_W'(tp));
        write_reg(CFG_BEEP_LENGTH, CFG_DATA_W'(bl));
        write_reg(CFG_BEEP_SPACING, CFG_DATA_W'(bs));
        write_reg(CFG_ON_DUTY, CFG_DATA_W'(duty));
        n_settings++;
    endtask

    // short periods so patterns wrap often; a random subset is rewritten so some
    // counters sit past their new period; one write goes to an unmapped index
    task automatic load_random_regs();
        int v [NUM_REGS];
        v[CFG_FAST_PERIOD]   = $urandom_range(0, 16);
        v[CFG_FAST_ON_TICKS] = $urandom_range(0, 18);
        v[CFG_LONG_PERIOD]   = $urandom_range(0, 24);
        v[CFG_LONG_ON_TICKS] = $urandom_range(0, 26);
        v[CFG_TRIPLE_PERIOD] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                            : $urandom_range(0, 60);
        v[CFG_BEEP_LENGTH]   = $urandom_range(0, 8);
        v[CFG_BEEP_SPACING]  = $urandom_range(0, 14);
        v[CFG_ON_DUTY]       = $urandom_range(0, 4095);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                write_reg(CFG_IDX_W'(i), CFG_DATA_W'(v[i]));
            end
        end
        write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom_range(0, 4095)));
        n_settings++;
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        // every block input known from time zero
        rst_n                 = 1'b0;
        item_bus.valid        = 1'b0;
        item_bus.mode         = MODE_TICK;
        item_bus.status_byte  = '0;
        item_bus.bus_degraded = 1'b0;
        item_bus.mute_request = 1'b0;
        item_bus.save_ok      = 1'b0;
        result_bus.ready      = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = '0;
        cfg_bus.data          = '0;
        n_queued     = 0;
        n_accepted   = 0;
        n_results    = 0;
        n_errors     = 0;
        n_ticks      = 0;
        n_mute_reqs  = 0;
        n_loud       = 0;
        n_save_fail  = 0;
        n_reg_writes = 0;
        n_settings   = 1;
        cycles       = 0;
        idling       = 1'b1;
        phase_no     = 0;
        alarm_scene  = '0;
        model_reset();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed beats at the reset settings
        queue_item(mk_item(MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b1));     // quiet
        queue_item(mk_item(MODE_TICK, 8'h20, 1'b0, 1'b0, 1'b1));     // interlock, fast beep
        queue_item(mk_item(MODE_TICK, 8'hFF, 1'b1, 1'b1, 1'b0));     // every alarm, byte all ones
        queue_item(mk_item(MODE_SET_MUTE, 8'h00, 1'b0, 1'b1, 1'b1)); // mute, save ok
        queue_item(mk_item(MODE_SET_MUTE, 8'h00, 1'b0, 1'b1, 1'b0)); // same value again
        queue_item(mk_item(MODE_TICK, 8'hFF, 1'b1, 1'b0, 1'b1));     // muted, nothing new
        queue_item(mk_item(MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b1));     // alarms clear
        queue_item(mk_item(MODE_TICK, 8'h01, 1'b0, 1'b0, 1'b0));     // rise, unmute save fails
        queue_item(mk_item(MODE_TICK, 8'h01, 1'b0, 1'b0, 1'b0));     // mask cleared, rises again
        queue_item(mk_item(MODE_TICK, 8'h01, 1'b0, 1'b0, 1'b1));     // unmute holds, triple
        queue_item(mk_item(MODE_SET_MUTE, 8'h00, 1'b0, 1'b0, 1'b0)); // unmute when unmuted
        queue_item(mk_item(MODE_SET_MUTE, 8'h00, 1'b0, 1'b1, 1'b0)); // new value, save fails
        queue_item(mk_item(MODE_SET_MUTE, 8'h00, 1'b0, 1'b1, 1'b1)); // mute
        queue_item(mk_item(MODE_SET_MUTE, 8'h00, 1'b0, 1'b0, 1'b1)); // unmute keeps level
        queue_item(mk_item(MODE_TICK, 8'hDE, 1'b0, 1'b1, 1'b1));     // only unrelated bits
        queue_item(mk_item(MODE_TICK, 8'h00, 1'b1, 1'b0, 1'b1));     // degraded, long beep
        queue_item(mk_item(MODE_TICK, 8'h21, 1'b1, 1'b1, 1'b0));     // interlock wins
        queue_item(mk_item(MODE_SET_MUTE, 8'hFF, 1'b1, 1'b0, 1'b1)); // ignored payload bits
        drain();

        // random beats at the reset settings, long triple period
        phase_no = 1;
        queue_random(200);
        drain();

        // low extremes: zero periods, zero lengths, zero duty
        phase_no = 2;
        load_regs(0, 0, 0, 0, 0, 0, 0, 0);
        write_reg(CFG_IDX_W'((1 << CFG_IDX_W) - 1), 12'hFFF);
        queue_random(150);
        drain();

        // high extremes: duty written above its width
        phase_no = 3;
        load_regs(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
        queue_random(150);
        drain();

        // a run of fresh short settings
        for (int p = 0; p < 5; p++)
        begin
            phase_no = 4 + p;
            load_random_regs();
            queue_random(200);
            drain();
        end

        // closing stretch with no idling at all
        phase_no = 9;
        idling   = 1'b0;
        load_random_regs();
        queue_random(200);
        drain();
        repeat (10) @(posedge clk);

        $display("ran %0d ticks and %0d mute requests over %0d register settings (%0d writes)",
                 n_ticks, n_mute_reqs, n_settings, n_reg_writes);
        $display("%0d results had the buzzer on, %0d reported a failed save, %0d mismatches",
                 n_loud, n_save_fail, n_errors);
        if (n_errors == 0 && expected_q.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
